// File: hdl/prefix_varint_decoder_assert.svh
// Assertion macros for the prefix varint decoder.
// Included by the top level; no other dependencies.
`ifndef PREFIX_VARINT_DECODER_ASSERT_SVH
`define PREFIX_VARINT_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define PVD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PVD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PVD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PVD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hdl/pvd_pkg.sv
// Package of the prefix varint decoder: request, result and status types,
// lead byte thresholds and field lengths. No dependencies.
`timescale 1ns / 1ps

package pvd_pkg;

    localparam logic [7:0] LEAD_2B = 8'h80;
    localparam logic [7:0] LEAD_4B = 8'hC0;
    localparam logic [7:0] LEAD_5B = 8'hE0;
    localparam logic [7:0] MASK_2B = 8'h3F;
    localparam logic [7:0] MASK_4B = 8'h1F;

    localparam logic [2:0] LEN_IDLE = 3'd0;
    localparam logic [2:0] LEN_1B   = 3'd1;
    localparam logic [2:0] LEN_2B   = 3'd2;
    localparam logic [2:0] LEN_4B   = 3'd4;
    localparam logic [2:0] LEN_5B   = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } pvd_req_t;

    typedef struct packed {
        logic signed [31:0] decoded_value;
        logic [2:0]         field_length;
        logic               truncated;
    } pvd_res_t;

    typedef struct packed {
        logic [2:0] bytes_needed;
        logic [2:0] bytes_seen;
        logic       little_endian_form;
    } pvd_stat_t;

endpackage

// File: hdl/pvd_in_if.sv
// Byte request channel of the prefix varint decoder.
// Depends on nothing but the handshake signals it declares.
`timescale 1ns / 1ps

interface pvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

// File: hdl/pvd_out_if.sv
// Decoded value channel of the prefix varint decoder.
// Depends on nothing but the handshake signals it declares.
`timescale 1ns / 1ps

interface pvd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] decoded_value;
    logic [2:0]         field_length;
    logic               truncated;

    modport source (output valid, output decoded_value, output field_length,
                    output truncated, input ready);
    modport sink   (input valid, input decoded_value, input field_length,
                    input truncated, output ready);
endinterface

// File: hdl/pvd_in_stage.sv
// Input register of the prefix varint decoder: holds one byte request.
// Depends on pvd_pkg and pvd_in_if.
`timescale 1ns / 1ps

module pvd_in_stage
(
    input  logic             clk,
    input  logic             rst_n,
    pvd_in_if.sink           byte_stream,
    input  logic             take,
    output logic             req_valid,
    output pvd_pkg::pvd_req_t req
);
    import pvd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    pvd_req_t req_reg;
    logic     accept;

    assign byte_stream.ready = !valid_reg || take;
    assign accept            = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.data_byte  <= byte_stream.data_byte;
            req_reg.buffer_end <= byte_stream.buffer_end;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;
endmodule

// File: hdl/pvd_core.sv
// Decode core: field state and the shift-or accumulator, one byte a cycle while the result register has space.
// Depends on pvd_pkg.
`timescale 1ns / 1ps

module pvd_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  pvd_pkg::pvd_req_t  req,
    input  logic               out_space,
    output logic               take,
    output logic               res_valid,
    output pvd_pkg::pvd_res_t  res,
    output pvd_pkg::pvd_stat_t stat
);
    import pvd_pkg::*;

    logic [2:0]  needed_reg;
    logic [2:0]  needed_next;
    logic [2:0]  seen_reg;
    logic [2:0]  seen_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        le_reg;
    logic        le_next;
    logic [2:0]  seen_inc;
    logic [31:0] acc_upd;
    logic [31:0] le_part;
    logic [7:0]  b;

    assign take = req_valid && out_space;
    assign b    = req.data_byte;

    assign seen_inc = seen_reg + 3'd1;

    always_comb
    begin
        le_part = 32'd0;
        case (seen_reg[1:0])
            2'd1:    le_part = {24'd0, b};
            2'd2:    le_part = {16'd0, b, 8'd0};
            2'd3:    le_part = {8'd0, b, 16'd0};
            2'd0:    le_part = {b, 24'd0};
            default: le_part = 32'd0;
        endcase
    end

    assign acc_upd = le_reg ? (acc_reg | le_part) : {acc_reg[23:0], b};

    always_comb
    begin
        needed_next = needed_reg;
        seen_next   = seen_reg;
        acc_next    = acc_reg;
        le_next     = le_reg;
        res_valid   = 1'b0;
        res         = '0;
        if (take)
        begin
            if (needed_reg == LEN_IDLE)
            begin
                if (b < LEAD_2B)
                begin
                    res_valid         = 1'b1;
                    res.decoded_value = {24'd0, b};
                    res.field_length  = LEN_1B;
                end
                else
                begin
                    seen_next = LEN_1B;
                    if (b < LEAD_4B)
                    begin
                        needed_next = LEN_2B;
                        acc_next    = {24'd0, b & MASK_2B};
                        le_next     = 1'b0;
                    end
                    else if (b < LEAD_5B)
                    begin
                        needed_next = LEN_4B;
                        acc_next    = {24'd0, b & MASK_4B};
                        le_next     = 1'b0;
                    end
                    else
                    begin
                        needed_next = LEN_5B;
                        acc_next    = 32'd0;
                        le_next     = 1'b1;
                    end
                    if (req.buffer_end)
                    begin
                        res_valid        = 1'b1;
                        res.field_length = LEN_1B;
                        res.truncated    = 1'b1;
                        needed_next      = LEN_IDLE;
                        seen_next        = LEN_IDLE;
                        acc_next         = 32'd0;
                        le_next          = 1'b0;
                    end
                end
            end
            else
            begin
                acc_next  = acc_upd;
                seen_next = seen_inc;
                if (seen_inc >= needed_reg)
                begin
                    res_valid         = 1'b1;
                    res.decoded_value = acc_upd;
                    res.field_length  = seen_inc;
                end
                else if (req.buffer_end)
                begin
                    res_valid        = 1'b1;
                    res.field_length = seen_inc;
                    res.truncated    = 1'b1;
                end
                if (res_valid)
                begin
                    needed_next = LEN_IDLE;
                    seen_next   = LEN_IDLE;
                    acc_next    = 32'd0;
                    le_next     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needed_reg <= LEN_IDLE;
            seen_reg   <= LEN_IDLE;
            acc_reg    <= 32'd0;
            le_reg     <= 1'b0;
        end
        else
        begin
            needed_reg <= needed_next;
            seen_reg   <= seen_next;
            acc_reg    <= acc_next;
            le_reg     <= le_next;
        end
    end

    assign stat.bytes_needed       = needed_reg;
    assign stat.bytes_seen         = seen_reg;
    assign stat.little_endian_form = le_reg;
endmodule

// File: hdl/pvd_out_stage.sv
// Result register of the prefix varint decoder: drives the value channel.
// Depends on pvd_pkg and pvd_out_if.
`timescale 1ns / 1ps

module pvd_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  pvd_pkg::pvd_res_t res,
    output logic              space,
    pvd_out_if.source         value_stream
);
    import pvd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    pvd_res_t res_reg;

    assign space = !valid_reg || value_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (value_stream.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign value_stream.valid         = valid_reg;
    assign value_stream.decoded_value = res_reg.decoded_value;
    assign value_stream.field_length  = res_reg.field_length;
    assign value_stream.truncated     = res_reg.truncated;
endmodule

// File: hdl/prefix_varint_decoder.sv
// Top level of the prefix varint decoder: input register, decode core, result register.
// Depends on pvd_pkg, pvd_in_if, pvd_out_if, the stage modules and the assert header.
//
//  channel        dir   handshake      payload
//  byte_stream    in    valid/ready    data_byte[7:0], buffer_end
//  value_stream   out   valid/ready    decoded_value[31:0], field_length[2:0], truncated
//
// One byte per cycle unless value_stream stalls; a result is presented in the cycle after
// its last byte is taken; the rate is set by the shift-or into the accumulator in pvd_core.
// Reset clears the field state; the decoder then waits for a lead byte.
// A stall on value_stream holds the core and fills the input register, then drops ready.
`timescale 1ns / 1ps
`include "prefix_varint_decoder_assert.svh"

module prefix_varint_decoder
(
    input  logic      clk,
    input  logic      rst_n,
    pvd_in_if.sink    byte_stream,
    pvd_out_if.source value_stream
);
    import pvd_pkg::*;

    logic      req_valid;
    pvd_req_t  req;
    logic      take;
    logic      res_valid;
    pvd_res_t  res;
    pvd_stat_t stat;
    logic      space;

    pvd_in_stage u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .take        (take),
        .req_valid   (req_valid),
        .req         (req)
    );

    pvd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .out_space (space),
        .take      (take),
        .res_valid (res_valid),
        .res       (res),
        .stat      (stat)
    );

    pvd_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_valid),
        .res          (res),
        .space        (space),
        .value_stream (value_stream)
    );

    `PVD_ASSERT_IMP(a_trunc_zero, clk, rst_n,
        value_stream.valid && value_stream.truncated,
        value_stream.decoded_value == 32'sd0,
        "truncated result carries a nonzero value")
    `PVD_ASSERT_IMP(a_full_len, clk, rst_n,
        value_stream.valid && !value_stream.truncated,
        value_stream.field_length == LEN_1B || value_stream.field_length == LEN_2B ||
        value_stream.field_length == LEN_4B || value_stream.field_length == LEN_5B,
        "complete field has an impossible length")
    `PVD_ASSERT_IMP(a_field_open, clk, rst_n,
        stat.bytes_needed != LEN_IDLE,
        stat.bytes_seen != LEN_IDLE && stat.bytes_seen < stat.bytes_needed,
        "open field byte count out of range")
    `PVD_ASSERT_IMP(a_no_overrun, clk, rst_n,
        value_stream.valid && !value_stream.ready,
        !take,
        "byte consumed while result register is blocked")
    `PVD_ASSERT_NXT(a_res_shown, clk, rst_n,
        res_valid,
        value_stream.valid,
        "result not presented after decode")
endmodule

// File: tb/tb_prefix_varint_decoder.sv
// Self-checking testbench for prefix_varint_decoder: sends byte buffers, predicts each
// decoded value and compares it field by field. Depends on pvd_pkg, pvd_in_if, pvd_out_if.
`timescale 1ns / 1ps

module tb_prefix_varint_decoder;

    import pvd_pkg::*;

    typedef enum int unsigned {FORM_1B, FORM_2B, FORM_4B, FORM_5B} form_e;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_TAIL  = 8;

    logic clk;
    logic rst_n;

    pvd_in_if  in_ch ();
    pvd_out_if out_ch ();

    prefix_varint_decoder dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (in_ch),
        .value_stream (out_ch)
    );

    pvd_res_t    expected_values[$];
    logic [2:0]  fld_total;
    logic [2:0]  fld_taken;
    logic [31:0] fld_acc;
    logic        fld_le;

    int unsigned in_gap_pct;
    int unsigned out_stall_pct;
    int unsigned hold_cycles;
    int unsigned idle_cycles;
    int unsigned err_count;
    int unsigned bytes_sent;
    int unsigned values_checked;
    int unsigned trunc_checked;

    always #10 clk = ~clk;

    task automatic push_value(input logic [31:0] v, input logic [2:0] len, input logic trunc);
        pvd_res_t r;
        r.decoded_value = v;
        r.field_length  = len;
        r.truncated     = trunc;
        expected_values.push_back(r);
        fld_total = LEN_IDLE;
        fld_taken = LEN_IDLE;
        fld_acc   = '0;
        fld_le    = 1'b0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        if (fld_total == LEN_IDLE) begin
            if (b < LEAD_2B) begin
                push_value({24'd0, b}, LEN_1B, 1'b0);
            end
            else begin
                if (b < LEAD_4B) begin
                    fld_total = LEN_2B;
                    fld_acc   = {24'd0, b & MASK_2B};
                    fld_le    = 1'b0;
                end
                else if (b < LEAD_5B) begin
                    fld_total = LEN_4B;
                    fld_acc   = {24'd0, b & MASK_4B};
                    fld_le    = 1'b0;
                end
                else begin
                    fld_total = LEN_5B;
                    fld_acc   = '0;
                    fld_le    = 1'b1;
                end
                fld_taken = LEN_1B;
                if (last)
                    push_value('0, LEN_1B, 1'b1);
            end
        end
        else begin
            if (fld_le)
                fld_acc = fld_acc | ({24'd0, b} << (5'((fld_taken - 3'd1) & 3'd3) * 5'd8));
            else
                fld_acc = {fld_acc[23:0], b};
            fld_taken = fld_taken + 3'd1;
            if (fld_taken >= fld_total)
                push_value(fld_acc, fld_taken, 1'b0);
            else if (last)
                push_value('0, fld_taken, 1'b1);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.data_byte  = b;
        in_ch.buffer_end = last;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_field(input form_e form, input bit end_flag, input bit cut);
        logic [7:0]  fb[$];
        int unsigned stop_at;
        int unsigned n;
        case (form)
            FORM_1B: fb.push_back(pick_byte() & ~LEAD_2B);
            FORM_2B: fb.push_back(LEAD_2B | (pick_byte() & MASK_2B));
            FORM_4B: fb.push_back(LEAD_4B | (pick_byte() & MASK_4B));
            default: fb.push_back(LEAD_5B | (pick_byte() & MASK_4B));
        endcase
        n = (form == FORM_2B) ? 1 : (form == FORM_4B) ? 3 : (form == FORM_5B) ? 4 : 0;
        repeat (n)
            fb.push_back(pick_byte());
        stop_at = (cut && fb.size() > 1) ? $urandom_range(fb.size() - 2) : fb.size() - 1;
        for (int unsigned i = 0; i <= stop_at; i++)
            send_byte(fb[i], (i == stop_at) ? (cut || end_flag) : 1'b0);
    endtask

    task automatic send_random_request();
        if ($urandom_range(99) < 6)
            send_byte(8'($urandom), 1'($urandom));
        else
            send_field(form_e'($urandom_range(3)), $urandom_range(99) < 20,
                       $urandom_range(99) < 10);
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hCC, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h12, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        in_gap_pct    = 0;
        out_stall_pct = 0;
        hold_cycles   = 150;
        repeat (12)
            send_random_request();
        wait_drained();
        in_gap_pct    = 37;
        out_stall_pct = 37;
    endtask

    task automatic test_no_idle(input int unsigned n);
        int unsigned stop_at;
        in_gap_pct    = 0;
        out_stall_pct = 0;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
            send_random_request();
        wait_drained();
        in_gap_pct    = 37;
        out_stall_pct = 37;
    endtask

    task automatic test_random_stream(input int unsigned n);
        int unsigned stop_at;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
            send_random_request();
        wait_drained();
    endtask

    always @(negedge clk) begin
        if (hold_cycles != 0) begin
            out_ch.ready = 1'b0;
            hold_cycles--;
        end
        else begin
            out_ch.ready = ($urandom_range(99) >= out_stall_pct);
        end
    end

    always @(posedge clk) begin
        pvd_res_t exp_r;
        if (rst_n === 1'b1) begin
            idle_cycles++;
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                idle_cycles = 0;
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                idle_cycles = 0;
                if (expected_values.size() == 0) begin
                    $error("decoded value with none expected: %0d", out_ch.decoded_value);
                    err_count++;
                end
                else begin
                    exp_r = expected_values.pop_front();
                    values_checked++;
                    if (exp_r.truncated)
                        trunc_checked++;
                    if (out_ch.decoded_value !== exp_r.decoded_value) begin
                        $error("decoded_value: expected %0d, actual %0d",
                               exp_r.decoded_value, out_ch.decoded_value);
                        err_count++;
                    end
                    if (out_ch.field_length !== exp_r.field_length) begin
                        $error("field_length: expected %0d, actual %0d",
                               exp_r.field_length, out_ch.field_length);
                        err_count++;
                    end
                    if (out_ch.truncated !== exp_r.truncated) begin
                        $error("truncated: expected %0d, actual %0d",
                               exp_r.truncated, out_ch.truncated);
                        err_count++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("stalled for %0d cycles with %0d values outstanding",
                         idle_cycles, expected_values.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.buffer_end = 1'b0;
        out_ch.ready     = 1'b0;
        in_gap_pct       = 37;
        out_stall_pct    = 37;
        hold_cycles      = 0;
        idle_cycles      = 0;
        err_count        = 0;
        bytes_sent       = 0;
        values_checked   = 0;
        trunc_checked    = 0;
        fld_total        = LEN_IDLE;
        fld_taken        = LEN_IDLE;
        fld_acc          = '0;
        fld_le           = 1'b0;
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random_stream(200);
        test_no_idle(60);
        test_random_stream(160);

        repeat (DRAIN_TAIL)
            @(posedge clk);
        if (expected_values.size() != 0) begin
            $error("%0d decoded values never arrived", expected_values.size());
            err_count++;
        end
        $display("Sent %0d bytes in all four field forms with cut buffers and noise;",
                 bytes_sent);
        $display("checked %0d values (%0d truncated) under random idling and a long stall.",
                 values_checked, trunc_checked);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/pvd_pkg.sv
hdl/pvd_in_if.sv
hdl/pvd_out_if.sv
hdl/pvd_in_stage.sv
hdl/pvd_core.sv
hdl/pvd_out_stage.sv
hdl/prefix_varint_decoder.sv
tb/tb_prefix_varint_decoder.sv
